/* rtl/core/acm_pkg.sv */
// Shared types and codes for the multi-pattern string matcher.
// Used by acm_ctl, acm_out and the top level; no dependencies.
package acm_pkg;

  localparam int NODES_DEF       = 256;
  localparam int ALPHABET_DEF    = 256;
  localparam int MATCH_SLOTS_DEF = 64;

  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_BUILD   = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_NOMATCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NODES_FULL  = 2'd1,
    ST_SLOTS_FULL  = 2'd2,
    ST_WRONG_PHASE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] id;
    logic [31:0] pos;
  } res_t;

  // push: one more match of the current item; flush: close the item
  typedef struct packed {
    logic push;
    logic flush;
    res_t item;
  } out_cmd_t;

endpackage

/* rtl/core/acm_out.sv */
// Result stage: holds back one match beat so the last flag can be set,
// and registers the outgoing beat. Depends on acm_pkg.
module acm_out import acm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  out_cmd_t    cmd,
  output logic        rdy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_match_id,
  output logic [31:0] out_position,
  output logic        out_last
);

  logic out_valid_r, out_valid_nxt;
  logic pend_v_r, pend_v_nxt;
  res_t out_r, out_nxt;
  res_t pend_r, pend_nxt;
  logic last_r, last_nxt;

  assign rdy = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    last_nxt      = last_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (cmd.push) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        last_nxt      = 1'b0;
      end
      pend_nxt   = cmd.item;
      pend_v_nxt = 1'b1;
    end
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      out_nxt       = pend_v_r ? pend_r : cmd.item;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    last_r <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_status   = out_r.status;
  assign out_match_id = out_r.id;
  assign out_position = out_r.pos;
  assign out_last     = last_r;

endmodule

/* rtl/core/acm_ctl.sv */
// Sequencer and memories of the matcher: trie, links, match lists, queue.
// Depends on acm_pkg; drives acm_out through an out_cmd_t.
module acm_ctl import acm_pkg::*; #(
  parameter int NODES       = NODES_DEF,
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int MATCH_SLOTS = MATCH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_symbol,
  input  logic        in_end_of_pattern,
  input  logic [15:0] in_pattern_id,
  input  logic        in_text_start,
  output out_cmd_t    cmd,
  input  logic        out_rdy
);

  localparam int NW  = $clog2(NODES);
  localparam int AW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int CTW = NW + AW;
  localparam int SIW = (MATCH_SLOTS > 1) ? $clog2(MATCH_SLOTS) : 1;
  localparam int SLW = $clog2(MATCH_SLOTS) + 1;
  localparam int NCW = $clog2(MATCH_SLOTS + 1);
  localparam logic [SLW-1:0] NO_SLOT  = {SLW{1'b1}};
  localparam logic [AW-1:0]  LAST_SYM = AW'(ALPHABET - 1);
  localparam int unsigned    SYM_RECIP = (65536 + ALPHABET - 1) / ALPHABET;

  typedef enum logic [23:0] {
    S_CLR  = 24'h000001, S_IDLE = 24'h000002, S_ACK  = 24'h000004,
    S_INS1 = 24'h000008, S_INS2 = 24'h000010, S_BINI = 24'h000020,
    S_BRA  = 24'h000040, S_BRB  = 24'h000080, S_BHD  = 24'h000100,
    S_BU   = 24'h000200, S_BFU  = 24'h000400, S_BCA  = 24'h000800,
    S_BCB  = 24'h001000, S_BFA  = 24'h002000, S_BFB  = 24'h004000,
    S_BFL  = 24'h008000, S_BDL  = 24'h010000, S_TB   = 24'h020000,
    S_TF   = 24'h040000, S_TD   = 24'h080000, S_TH   = 24'h100000,
    S_TS   = 24'h200000, S_TE   = 24'h400000, S_TEND = 24'h800000
  } state_t;

  state_t state_r, state_nxt;
  mode_t   mode_r, mode_nxt;
  status_t stat_r, stat_nxt;
  logic [AW-1:0]  sym_r, sym_nxt, s_r, s_nxt;
  logic           eop_r, eop_nxt;
  logic [15:0]    pid_r, pid_nxt;
  logic [NW:0]    nodes_used_r, nodes_used_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [SLW-1:0] slots_used_r, slots_used_nxt, t_r, t_nxt;
  logic [NW-1:0]  cursor_r, cursor_nxt, scan_node_r, scan_node_nxt, node_r, node_nxt;
  logic [NW-1:0]  u_r, u_nxt, fu_r, fu_nxt, f_r, f_nxt, v_r, v_nxt, c_r, c_nxt;
  logic [NW-1:0]  d_r, d_nxt, dnext_r, dnext_nxt;
  logic [31:0]    scan_pos_r, scan_pos_nxt, pos_r, pos_nxt;
  logic           built_r, built_nxt;
  logic [SIW-1:0] slot_r, slot_nxt;
  logic [CTW-1:0] clr_r, clr_nxt;
  logic [NCW-1:0] n_r, n_nxt;

  // memory ports
  logic [NW-1:0]  ct_mem [2**CTW];
  logic [NW-1:0]  fl_mem [NODES];
  logic [NW-1:0]  dl_mem [NODES];
  logic [SLW-1:0] oh_mem [NODES];
  logic [SIW-1:0] ot_mem [NODES];
  logic [15:0]    sid_mem [MATCH_SLOTS];
  logic [SLW-1:0] snx_mem [MATCH_SLOTS];
  logic [NW-1:0]  bq_mem [NODES];

  logic [CTW-1:0] ct_ra, ct_wa;
  logic [NW-1:0]  ct_q, ct_wd;
  logic           ct_we;
  logic [NW-1:0]  fl_ra, fl_wa, fl_wd, fl_q;
  logic           fl_we;
  logic [NW-1:0]  dl_ra, dl_wa, dl_wd, dl_q;
  logic           dl_we;
  logic [NW-1:0]  oh_ra, oh_wa;
  logic [SLW-1:0] oh_wd, oh_q;
  logic           oh_we;
  logic [NW-1:0]  ot_ra, ot_wa;
  logic [SIW-1:0] ot_wd, ot_q;
  logic           ot_we;
  logic [SIW-1:0] sl_ra, sid_wa, snx_wa;
  logic [15:0]    sid_wd, sid_q;
  logic [SLW-1:0] snx_wd, snx_q;
  logic           sid_we, snx_we;
  logic [NW-1:0]  bq_ra, bq_wa, bq_wd, bq_q;
  logic           bq_we;

  logic [23:0]    sym_prod;
  logic [7:0]     sym_quot;
  logic [15:0]    sym_back;
  logic [7:0]     in_sym_full;
  logic [AW-1:0]  in_sym;
  logic [NW-1:0]  in_node, cnode, nnode;
  logic [31:0]    base_pos;
  logic           accept;

  // symbol modulo alphabet by reciprocal multiplication, exact for any byte
  assign sym_prod    = {16'd0, in_symbol} * 24'(SYM_RECIP);
  assign sym_quot    = sym_prod[23:16];
  assign sym_back    = {8'd0, sym_quot} * 16'(ALPHABET);
  assign in_sym_full = in_symbol - sym_back[7:0];
  assign in_sym      = in_sym_full[AW-1:0];
  assign in_node     = in_text_start ? '0 : scan_node_r;
  assign base_pos    = in_text_start ? '0 : scan_pos_r;
  assign in_stall    = (state_r != S_IDLE);
  assign accept      = in_valid && (state_r == S_IDLE);
  assign sl_ra       = t_r[SIW-1:0];
  assign cnode       = (ct_q == '0) ? nodes_used_r[NW-1:0] : ct_q;
  assign nnode       = (ct_q != '0) ? ct_q : node_r;

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;     stat_nxt = stat_r;
    sym_nxt = sym_r;       s_nxt = s_r;           eop_nxt = eop_r;
    pid_nxt = pid_r;       nodes_used_nxt = nodes_used_r;
    head_nxt = head_r;     tail_nxt = tail_r;     slots_used_nxt = slots_used_r;
    t_nxt = t_r;           cursor_nxt = cursor_r; scan_node_nxt = scan_node_r;
    node_nxt = node_r;     u_nxt = u_r;           fu_nxt = fu_r;
    f_nxt = f_r;           v_nxt = v_r;           c_nxt = c_r;
    d_nxt = d_r;           dnext_nxt = dnext_r;   scan_pos_nxt = scan_pos_r;
    pos_nxt = pos_r;       built_nxt = built_r;   slot_nxt = slot_r;
    clr_nxt = clr_r;       n_nxt = n_r;

    ct_ra = {node_r, sym_r}; ct_we = 1'b0; ct_wa = {cursor_r, sym_r}; ct_wd = '0;
    fl_ra = node_r; fl_we = 1'b0; fl_wa = v_r; fl_wd = '0;
    dl_ra = d_r;    dl_we = 1'b0; dl_wa = v_r; dl_wd = '0;
    oh_ra = d_r;    oh_we = 1'b0; oh_wa = node_r; oh_wd = NO_SLOT;
    ot_ra = cnode;  ot_we = 1'b0; ot_wa = node_r; ot_wd = slot_r;
    sid_we = 1'b0;  sid_wa = slot_r; sid_wd = pid_r;
    snx_we = 1'b0;  snx_wa = slot_r; snx_wd = NO_SLOT;
    bq_ra = head_r[NW-1:0]; bq_we = 1'b0; bq_wa = tail_r[NW-1:0]; bq_wd = v_r;

    cmd.push  = 1'b0;
    cmd.flush = 1'b0;
    cmd.item  = '{kind: KIND_ACK, status: stat_r, id: 16'd0, pos: 32'd0};

    case (state_r)
      S_CLR: begin
        ct_we = 1'b1; ct_wa = clr_r; ct_wd = '0;
        oh_we = 1'b1; oh_wa = clr_r[NW-1:0]; oh_wd = NO_SLOT;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt = mode_t'(in_mode);
          sym_nxt  = in_sym;
          eop_nxt  = in_end_of_pattern;
          pid_nxt  = in_pattern_id;
          stat_nxt = ST_OK;
          case (mode_t'(in_mode))
            MODE_PATTERN: begin
              ct_ra = {cursor_r, in_sym};
              if (built_r) begin
                stat_nxt  = ST_WRONG_PHASE;
                state_nxt = S_ACK;
              end else begin
                state_nxt = S_INS1;
              end
            end
            MODE_BUILD: state_nxt = S_BINI;
            MODE_TEXT: begin
              if (!built_r) begin
                stat_nxt  = ST_WRONG_PHASE;
                state_nxt = S_ACK;
              end else begin
                ct_ra        = {in_node, in_sym};
                node_nxt     = in_node;
                pos_nxt      = base_pos;
                scan_pos_nxt = (base_pos == '1) ? base_pos : base_pos + 32'd1;
                state_nxt    = S_TB;
              end
            end
            default: begin
              // clear all: scalars now, tables in the sweep after the ack
              nodes_used_nxt = (NW+1)'(1);
              slots_used_nxt = '0;
              cursor_nxt     = '0;
              scan_node_nxt  = '0;
              scan_pos_nxt   = '0;
              built_nxt      = 1'b0;
              clr_nxt        = '0;
              state_nxt      = S_ACK;
            end
          endcase
        end
      end
      S_ACK: begin
        cmd.flush = out_rdy;
        if (out_rdy) state_nxt = (mode_r == MODE_CLEAR) ? S_CLR : S_IDLE;
      end
      S_INS1: begin
        state_nxt = S_ACK;
        oh_ra = cnode;
        if (ct_q == '0 && nodes_used_r >= (NW+1)'(NODES)) begin
          stat_nxt = ST_NODES_FULL;
          if (eop_r) cursor_nxt = '0;
        end else begin
          if (ct_q == '0) begin
            ct_we = 1'b1; ct_wd = nodes_used_r[NW-1:0];
            nodes_used_nxt = nodes_used_r + 1'b1;
          end
          cursor_nxt = cnode;
          if (eop_r) begin
            cursor_nxt = '0;
            if (slots_used_r >= SLW'(MATCH_SLOTS)) begin
              stat_nxt = ST_SLOTS_FULL;
            end else begin
              slot_nxt = slots_used_r[SIW-1:0];
              slots_used_nxt = slots_used_r + 1'b1;
              sid_we = 1'b1; sid_wa = slots_used_r[SIW-1:0];
              snx_we = 1'b1; snx_wa = slots_used_r[SIW-1:0]; snx_wd = NO_SLOT;
              node_nxt  = cnode;
              state_nxt = S_INS2;
            end
          end
        end
      end
      S_INS2: begin
        // append at the tail so the list keeps insertion order
        if (oh_q == NO_SLOT) begin
          oh_we = 1'b1; oh_wd = SLW'(slot_r);
        end else begin
          snx_we = 1'b1; snx_wa = ot_q; snx_wd = SLW'(slot_r);
        end
        ot_we = 1'b1;
        state_nxt = S_ACK;
      end
      S_BINI: begin
        fl_we = 1'b1; fl_wa = '0; fl_wd = '0;
        dl_we = 1'b1; dl_wa = '0; dl_wd = '0;
        s_nxt = '0; head_nxt = '0; tail_nxt = '0;
        state_nxt = S_BRA;
      end
      S_BRA: begin
        ct_ra = {{NW{1'b0}}, s_r};
        state_nxt = S_BRB;
      end
      S_BRB: begin
        if (ct_q != '0 && tail_r < (NW+1)'(NODES)) begin
          fl_we = 1'b1; fl_wa = ct_q; fl_wd = '0;
          dl_we = 1'b1; dl_wa = ct_q; dl_wd = '0;
          bq_we = 1'b1; bq_wd = ct_q;
          tail_nxt = tail_r + 1'b1;
        end
        if (s_r == LAST_SYM) begin
          state_nxt = S_BHD;
        end else begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_BRA;
        end
      end
      S_BHD: begin
        if (head_r == tail_r) begin
          built_nxt     = 1'b1;
          scan_node_nxt = '0;
          scan_pos_nxt  = '0;
          stat_nxt      = ST_OK;
          state_nxt     = S_ACK;
        end else begin
          state_nxt = S_BU;
        end
      end
      S_BU: begin
        u_nxt = bq_q;
        fl_ra = bq_q;
        head_nxt = head_r + 1'b1;
        state_nxt = S_BFU;
      end
      S_BFU: begin
        fu_nxt = fl_q;
        s_nxt = '0;
        state_nxt = S_BCA;
      end
      S_BCA: begin
        ct_ra = {u_r, s_r};
        state_nxt = S_BCB;
      end
      S_BCB: begin
        if (ct_q == '0) begin
          if (s_r == LAST_SYM) begin
            state_nxt = S_BHD;
          end else begin
            s_nxt = s_r + 1'b1;
            state_nxt = S_BCA;
          end
        end else begin
          v_nxt = ct_q;
          f_nxt = fu_r;
          state_nxt = S_BFA;
        end
      end
      S_BFA: begin
        ct_ra = {f_r, s_r};
        state_nxt = S_BFB;
      end
      S_BFB: begin
        if (f_r != '0 && ct_q == '0) begin
          fl_ra = f_r;
          state_nxt = S_BFL;
        end else begin
          c_nxt = ct_q;
          oh_ra = ct_q;
          dl_ra = ct_q;
          state_nxt = S_BDL;
        end
      end
      S_BFL: begin
        f_nxt = fl_q;
        state_nxt = S_BFA;
      end
      S_BDL: begin
        fl_we = 1'b1; fl_wd = c_r;
        dl_we = 1'b1; dl_wd = (oh_q != NO_SLOT) ? c_r : dl_q;
        if (tail_r < (NW+1)'(NODES)) begin
          bq_we = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        if (s_r == LAST_SYM) begin
          state_nxt = S_BHD;
        end else begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_BCA;
        end
      end
      S_TB: begin
        if (node_r != '0 && ct_q == '0) begin
          fl_ra = node_r;
          state_nxt = S_TF;
        end else begin
          scan_node_nxt = nnode;
          d_nxt = nnode;
          n_nxt = '0;
          state_nxt = S_TD;
        end
      end
      S_TF: begin
        node_nxt = fl_q;
        ct_ra = {fl_q, sym_r};
        state_nxt = S_TB;
      end
      S_TD: begin
        if (d_r == '0) begin
          state_nxt = S_TEND;
        end else begin
          state_nxt = S_TH;
        end
      end
      S_TH: begin
        t_nxt = oh_q;
        dnext_nxt = dl_q;
        state_nxt = S_TS;
      end
      S_TS: begin
        if (t_r == NO_SLOT || n_r >= NCW'(MATCH_SLOTS)) begin
          d_nxt = dnext_r;
          state_nxt = S_TD;
        end else begin
          state_nxt = S_TE;
        end
      end
      S_TE: begin
        cmd.item = '{kind: KIND_MATCH, status: ST_OK, id: sid_q, pos: pos_r};
        cmd.push = out_rdy;
        if (out_rdy) begin
          n_nxt = n_r + 1'b1;
          t_nxt = snx_q;
          state_nxt = S_TS;
        end
      end
      S_TEND: begin
        cmd.item  = '{kind: KIND_NOMATCH, status: ST_OK, id: 16'd0, pos: pos_r};
        cmd.flush = out_rdy;
        if (out_rdy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      nodes_used_r <= (NW+1)'(1);
      slots_used_r <= '0;
      cursor_r     <= '0;
      scan_node_r  <= '0;
      scan_pos_r   <= '0;
      built_r      <= 1'b0;
      mode_r       <= MODE_PATTERN;
      head_r       <= '0;
      tail_r       <= '0;
      n_r          <= '0;
      s_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      nodes_used_r <= nodes_used_nxt;
      slots_used_r <= slots_used_nxt;
      cursor_r     <= cursor_nxt;
      scan_node_r  <= scan_node_nxt;
      scan_pos_r   <= scan_pos_nxt;
      built_r      <= built_nxt;
      mode_r       <= mode_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      n_r          <= n_nxt;
      s_r          <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;   sym_r <= sym_nxt;     eop_r <= eop_nxt;
    pid_r <= pid_nxt;     t_r <= t_nxt;         node_r <= node_nxt;
    u_r <= u_nxt;         fu_r <= fu_nxt;       f_r <= f_nxt;
    v_r <= v_nxt;         c_r <= c_nxt;         d_r <= d_nxt;
    dnext_r <= dnext_nxt; pos_r <= pos_nxt;     slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_wa] <= ct_wd;
    ct_q <= ct_mem[ct_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_q <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    dl_q <= dl_mem[dl_ra];
  end

  always_ff @(posedge clk) begin
    if (oh_we) oh_mem[oh_wa] <= oh_wd;
    oh_q <= oh_mem[oh_ra];
  end

  always_ff @(posedge clk) begin
    if (ot_we) ot_mem[ot_wa] <= ot_wd;
    ot_q <= ot_mem[ot_ra];
  end

  always_ff @(posedge clk) begin
    if (sid_we) sid_mem[sid_wa] <= sid_wd;
    sid_q <= sid_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (snx_we) snx_mem[snx_wa] <= snx_wd;
    snx_q <= snx_mem[sl_ra];
  end

  always_ff @(posedge clk) begin
    if (bq_we) bq_mem[bq_wa] <= bq_wd;
    bq_q <= bq_mem[bq_ra];
  end

endmodule

/* rtl/core/multi_pattern_string_matcher.sv */
// Top level of the multi-pattern string matcher (Aho-Corasick automaton).
// Instantiates acm_ctl and acm_out; depends on acm_pkg.
//
// Patterns are loaded a byte at a time (mode 0), failure links are built by
// one build beat (mode 1), then text bytes (mode 2) return every pattern id
// ending at that byte, or one no-match beat; every other beat gets one
// acknowledge. One item is worked at a time. After reset and after a clear
// beat (mode 3) the block runs a clearing pass over the child table's
// 2**(clog2(NODES)+clog2(ALPHABET)) entries (65536 by default) and takes no
// item meanwhile. A pattern byte reads the child table, then adds a node if
// needed and, when it ends a pattern, a match slot; it is then acknowledged.
// A text byte follows failure links until a child exists, walks the
// dictionary chain reporting each match, then closes the item. A build
// scans every symbol of the root and then of each queued node, follows
// failure links for each child found, sets its links and queues it. The
// child table and link memories have registered reads, each step waiting
// on the last read; output stalls add to the time taken.
module multi_pattern_string_matcher import acm_pkg::*; #(
  parameter int NODES       = NODES_DEF,
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int MATCH_SLOTS = MATCH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_symbol,
  input  logic        in_end_of_pattern,
  input  logic [15:0] in_pattern_id,
  input  logic        in_text_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_match_id,
  output logic [31:0] out_position,
  output logic        out_last
);

  out_cmd_t cmd;
  logic     out_rdy;

  acm_ctl #(
    .NODES       (NODES),
    .ALPHABET    (ALPHABET),
    .MATCH_SLOTS (MATCH_SLOTS)
  ) u_ctl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_symbol         (in_symbol),
    .in_end_of_pattern (in_end_of_pattern),
    .in_pattern_id     (in_pattern_id),
    .in_text_start     (in_text_start),
    .cmd               (cmd),
    .out_rdy           (out_rdy)
  );

  acm_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rdy          (out_rdy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_status   (out_status),
    .out_match_id (out_match_id),
    .out_position (out_position),
    .out_last     (out_last)
  );

endmodule
